// File: rtl/rpcf_pkg.sv
package rpcf_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int FEC_BYTES   = 4;

    localparam logic [1:0] REG_PAYLOAD_LENGTH  = 2'd0;
    localparam logic [1:0] REG_SCRAMBLE_ENABLE = 2'd1;
    localparam logic [1:0] REG_TX_ADDRESS      = 2'd2;
    localparam logic [1:0] REG_CRC_POLYNOMIAL  = 2'd3;

    localparam logic [4:0]  PAYLOAD_LENGTH_RESET = 5'd16;
    localparam logic [15:0] CRC_POLY_RESET       = 16'h1021;
    localparam logic [7:0]  SYNC_BYTE            = 8'hC3;
    localparam logic [7:0]  CRC_XOR_HI           = 8'hAE;
    localparam logic [7:0]  CRC_XOR_LO           = 8'hE4;
    localparam logic [3:0]  NIB_ONE              = 4'hC;
    localparam logic [3:0]  NIB_ZERO             = 4'h3;

    localparam logic [7:0] WHITEN_TAB [16] = '{
        8'hD0, 8'h9E, 8'h53, 8'h33, 8'hD8, 8'hBA, 8'h98, 8'h08,
        8'h24, 8'hCB, 8'h3B, 8'hFC, 8'h71, 8'hA3, 8'hF4, 8'h55
    };

    // One classified payload byte, handed from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [31:0] addr;
        logic [15:0] crc_code;
    } cmd_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    // Coded byte k of the four that one byte expands to.
    function automatic logic [7:0] fec_byte(input logic [7:0] b, input logic [1:0] k);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = b[{k, 1'b0}] ? NIB_ONE : NIB_ZERO;
        lo = b[{k, 1'b1}] ? NIB_ONE : NIB_ZERO;
        return rev8({hi, lo});
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [15:0] poly,
                                             input logic [7:0] a);
        logic [15:0] c;
        c = crc ^ {a, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Address bytes past the fourth are zero; all are sent bit-reversed.
    function automatic logic [7:0] addr_byte(input logic [31:0] addr, input logic [2:0] i);
        logic [1:0] j;
        j = 2'd3 - i[1:0];
        return i[2] ? 8'h00 : rev8(addr[{j, 3'b000} +: 8]);
    endfunction

endpackage

// File: rtl/radio_packet_crc_fec_framer_unit.sv
// Radio frame coder. Each payload byte on the input stream is optionally whitened,
// folded into a CRC-16 and expanded into four repetition-coded bytes; the first
// byte of a frame is preceded by ADDR_BYTES address bytes and two sync bytes, and
// the last byte is followed by the eight coded CRC bytes, with tuser marking the
// end of the frame and tlast the last output byte of each input item. The output
// side sends one byte per cycle while m_tready is high, so an item takes 4 bytes
// in the middle of a frame, ADDR_BYTES+6 on the first byte, 12 on the last byte and
// ADDR_BYTES+14 when a frame has a single byte. The front end whitens and updates
// the CRC in the cycle an item is accepted and keeps taking items while a
// two-entry queue in front of the byte expander has room.
module radio_packet_crc_fec_framer_unit
    import rpcf_pkg::*;
#(
    parameter int ADDR_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,
    output logic        m_tuser    // frame_end
);

    logic push;
    logic push_ready;
    cmd_t cmd;
    logic pop;
    logic q_valid;
    cmd_t q_data;

    rpcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_ready   (push_ready),
        .push      (push),
        .cmd       (cmd)
    );

    rpcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    rpcf_back #(
        .ADDR_BYTES (ADDR_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The end of a frame is always the last byte of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without item end");

    // A byte that opens a frame without closing it is never followed by another opener.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && cmd.first && !cmd.last |=> !(push && cmd.first))
        else $error("frame restarted without an end");

    // The expander never takes an item from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// File: rtl/rpcf_front.sv
module rpcf_front
    import rpcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        q_ready,
    output logic        push,
    output cmd_t        cmd
);

    logic [4:0]  len_reg,  len_next;
    logic        scr_reg,  scr_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] poly_reg, poly_next;
    logic [3:0]  pos_reg,  pos_next;
    logic [15:0] crc_reg,  crc_next;

    logic [4:0]  len_eff;
    logic        last;
    logic [7:0]  b;
    logic [15:0] crc_new;

    assign s_tready = q_ready;
    assign push     = s_tvalid && q_ready;

    always_comb
    begin
        if (len_reg == 5'd0)
        begin
            len_eff = 5'd1;
        end
        else if (len_reg > 5'(MAX_PAYLOAD))
        begin
            len_eff = 5'(MAX_PAYLOAD);
        end
        else
        begin
            len_eff = len_reg;
        end
        last    = ({1'b0, pos_reg} + 5'd1) >= len_eff;
        b       = s_tdata ^ (scr_reg ? WHITEN_TAB[pos_reg] : 8'h00);
        crc_new = crc_byte((pos_reg == 4'd0) ? 16'h0000 : crc_reg, poly_reg, rev8(b));

        cmd.data     = b;
        cmd.first    = (pos_reg == 4'd0);
        cmd.last     = last;
        cmd.addr     = addr_reg;
        cmd.crc_code = {rev8(crc_new[15:8]) ^ (scr_reg ? CRC_XOR_HI : 8'h00),
                        rev8(crc_new[7:0])  ^ (scr_reg ? CRC_XOR_LO : 8'h00)};
    end

    always_comb
    begin
        len_next  = len_reg;
        scr_next  = scr_reg;
        addr_next = addr_reg;
        poly_next = poly_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PAYLOAD_LENGTH:  len_next  = cfg_data[4:0];
                REG_SCRAMBLE_ENABLE: scr_next  = cfg_data[0];
                REG_TX_ADDRESS:      addr_next = cfg_data;
                REG_CRC_POLYNOMIAL:  poly_next = cfg_data[15:0];
                default:             len_next  = len_reg;
            endcase
        end

        pos_next = pos_reg;
        crc_next = crc_reg;
        if (push)
        begin
            if (last)
            begin
                pos_next = 4'd0;
                crc_next = 16'h0000;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
                crc_next = crc_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= PAYLOAD_LENGTH_RESET;
            scr_reg  <= 1'b0;
            addr_reg <= 32'h0000_0000;
            poly_reg <= CRC_POLY_RESET;
            pos_reg  <= 4'd0;
            crc_reg  <= 16'h0000;
        end
        else
        begin
            len_reg  <= len_next;
            scr_reg  <= scr_next;
            addr_reg <= addr_next;
            poly_reg <= poly_next;
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
        end
    end

endmodule

// File: rtl/rpcf_queue.sv
module rpcf_queue
    import rpcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/rpcf_back.sv
module rpcf_back
    import rpcf_pkg::*;
#(
    parameter int ADDR_BYTES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_data,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    // Sequence index: address bytes, two sync bytes, then 4 data and 8 CRC bytes.
    localparam int SEQ_W = $clog2(ADDR_BYTES + 3 * FEC_BYTES + 2);
    localparam logic [SEQ_W-1:0] ADDR_END = SEQ_W'(ADDR_BYTES);
    localparam logic [SEQ_W-1:0] HEAD_IDX = SEQ_W'(ADDR_BYTES + 2);
    localparam logic [SEQ_W-1:0] DATA_END = SEQ_W'(ADDR_BYTES + 2 + FEC_BYTES - 1);
    localparam logic [SEQ_W-1:0] CRC_END  = SEQ_W'(ADDR_BYTES + 2 + 3 * FEC_BYTES - 1);

    cmd_t             cur_reg,       cur_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [SEQ_W-1:0] seq_reg,       seq_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg,  out_byte_next;
    logic             out_last_reg,  out_last_next;
    logic             out_end_reg,   out_end_next;

    logic             adv;
    logic             at_end;
    logic [SEQ_W-1:0] rel;
    logic [7:0]       byte_sel;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    always_comb
    begin
        adv    = cur_valid_reg && (!out_valid_reg || m_tready);
        at_end = (seq_reg == (cur_reg.last ? CRC_END : DATA_END));
        pop    = q_valid && (!cur_valid_reg || (adv && at_end));
        rel    = seq_reg - HEAD_IDX;

        if (seq_reg < ADDR_END)
        begin
            byte_sel = addr_byte(cur_reg.addr, seq_reg[2:0]);
        end
        else if (seq_reg < HEAD_IDX)
        begin
            byte_sel = SYNC_BYTE;
        end
        else
        begin
            case (rel[3:2])
                2'd0:    byte_sel = fec_byte(cur_reg.data, rel[1:0]);
                2'd1:    byte_sel = fec_byte(cur_reg.crc_code[15:8], rel[1:0]);
                default: byte_sel = fec_byte(cur_reg.crc_code[7:0], rel[1:0]);
            endcase
        end

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        seq_next       = seq_reg;
        if (pop)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            seq_next       = q_data.first ? '0 : HEAD_IDX;
        end
        else if (adv && at_end)
        begin
            cur_valid_next = 1'b0;
        end
        else if (adv)
        begin
            seq_next = seq_reg + SEQ_W'(1);
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_sel;
            out_last_next  = at_end;
            out_end_next   = at_end && cur_reg.last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
